// ===== rtl/imu_frame_decoder_defines.svh =====
// Assertion macros shared by the frame decoder RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef IMU_FRAME_DECODER_DEFINES_SVH
`define IMU_FRAME_DECODER_DEFINES_SVH

// Check on every clock edge outside reset
`define IMU_FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included
`define IMU_FD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/imu_fd_pkg.sv =====
// Types, register indexes and scale constants of the frame decoder.
// No dependencies; used by the converter and the top level.
package imu_fd_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int NUM_KINDS   = 6;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int PAY_BYTES   = FRAME_BYTES - 3;
  localparam int PAY_W       = 8 * PAY_BYTES;
  localparam int NUM_WORDS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_EN = 3'd7;

  // Register reset values
  localparam logic [7:0] HEADER_RST  = 8'd85;
  localparam logic [7:0] TIME_RST    = 8'd80;
  localparam logic [7:0] ACCEL_RST   = 8'd81;
  localparam logic [7:0] GYRO_RST    = 8'd82;
  localparam logic [7:0] ANGLE_RST   = 8'd83;
  localparam logic [7:0] MAG_RST     = 8'd84;
  localparam logic [7:0] QUAT_RST    = 8'd89;
  localparam logic [NUM_KINDS-1:0] CONV_EN_RST = 6'h3f;

  // Full-scale factors: raw/32768 * range, times 65536 for Q16.16
  localparam logic signed [31:0] GYRO_SCALE  = 32'sd2000 * 32'sd65536 / 32'sd32768;
  localparam logic signed [31:0] ANGLE_SCALE = 32'sd180 * 32'sd65536 / 32'sd32768;

  typedef enum logic [2:0] {
    KIND_TIME  = 3'd0,
    KIND_ACCEL = 3'd1,
    KIND_GYRO  = 3'd2,
    KIND_ANGLE = 3'd3,
    KIND_MAG   = 3'd4,
    KIND_QUAT  = 3'd5
  } kind_e;

  // Control of one word converter
  typedef struct packed {
    logic  en;
    kind_e kind;
  } conv_ctl_t;

endpackage

// ===== rtl/imu_fd_ifs.sv =====
// Valid/ready channels of the frame decoder: byte input and frame result.
// Depends on nothing.
interface imu_fd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_kind;
  logic [63:0]        payload;
  logic signed [31:0] conv_first;
  logic signed [31:0] conv_second;
  logic signed [31:0] conv_third;
  logic signed [31:0] conv_fourth;
  logic               conv_valid;

  modport source (output valid, output frame_kind, output payload, output conv_first,
                  output conv_second, output conv_third, output conv_fourth,
                  output conv_valid, input ready);
  modport sink   (input valid, input frame_kind, input payload, input conv_first,
                  input conv_second, input conv_third, input conv_fourth,
                  input conv_valid, output ready);
endinterface

// ===== rtl/imu_fd_cell.sv =====
// One byte cell of the receive window; hands its byte to the older neighbor.
// No package dependencies.
module imu_fd_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] byte_q;

  // Take the younger neighbor's byte on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= data_i;
    end
  end

  assign data_o = byte_q;

endmodule

// ===== rtl/imu_fd_conv.sv =====
// Converts one raw little-endian 16-bit sensor word to signed Q16.16.
// Depends on imu_fd_pkg for the kind codes and scale factors.
module imu_fd_conv (
  input  imu_fd_pkg::conv_ctl_t   ctl_i,
  input  logic signed [15:0]      raw_i,
  output logic signed [31:0]      word_o
);
  import imu_fd_pkg::*;

  logic signed [31:0] raw_ext;

  assign raw_ext = {{16{raw_i[15]}}, raw_i};

  // Scale by kind; powers of two are shifts, the rest constant multiplies
  always_comb begin
    word_o = '0;
    if (ctl_i.en) begin
      case (ctl_i.kind)
        KIND_ACCEL: word_o = {raw_ext[26:0], 5'b0};
        KIND_GYRO:  word_o = raw_ext * GYRO_SCALE;
        KIND_ANGLE: word_o = raw_ext * ANGLE_SCALE;
        KIND_MAG:   word_o = {raw_i, 16'b0};
        KIND_QUAT:  word_o = {raw_ext[30:0], 1'b0};
        default:    word_o = '0;
      endcase
    end
  end

endmodule

// ===== rtl/imu_frame_decoder.sv =====
// Frame decoder top level: byte cell chain, frame check and conversion stages.
// Depends on imu_fd_pkg, imu_fd_ifs, imu_fd_cell, imu_fd_conv and the defines header.
// A result passes through the match stage and then the output register after the beat carrying its checksum byte.
// Throughput: one byte per cycle, set by the shift of the cell chain
// and the running checksum register; every stage stalls together on output backpressure.
// Reset: registers that have a reset take their reset values at once; the window clears, no sweep.
`include "imu_frame_decoder_defines.svh"

module imu_frame_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  imu_fd_in_if.sink                          in_ch,
  imu_fd_out_if.source                       out_ch,
  input  logic                               cfg_we_i,
  input  logic [imu_fd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [imu_fd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import imu_fd_pkg::*;

  // Configuration registers
  logic [7:0]           header_q;
  logic [7:0]           type_q [NUM_KINDS];
  logic [NUM_KINDS-1:0] conv_en_q;

  // Window and check state
  logic [7:0]        win [FRAME_BYTES];
  logic [7:0]        sum_q;
  logic [FILL_W-1:0] fill_q;
  logic              chk_v_q;

  // Match stage
  logic              s1_v_q;
  kind_e             s1_kind_q;
  logic [PAY_W-1:0]  s1_pay_q;
  logic              s1_cv_q;

  // Output register
  logic               out_v_q;
  kind_e              out_kind_q;
  logic [PAY_W-1:0]   out_pay_q;
  logic signed [31:0] out_word_q [NUM_WORDS];
  logic               out_cv_q;

  logic              advance;
  logic              acc;
  logic              hdr_ok;
  logic              sum_ok;
  logic              type_hit;
  kind_e             type_kind;
  logic [PAY_W-1:0]  pay;
  logic signed [31:0] word [NUM_WORDS];
  conv_ctl_t          ctl [NUM_WORDS];

  assign advance     = !out_v_q || out_ch.ready;
  assign in_ch.ready = advance;
  assign acc         = in_ch.valid && advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RST;
      type_q[0] <= TIME_RST;
      type_q[1] <= ACCEL_RST;
      type_q[2] <= GYRO_RST;
      type_q[3] <= ANGLE_RST;
      type_q[4] <= MAG_RST;
      type_q[5] <= QUAT_RST;
      conv_en_q <= CONV_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        CFG_HEADER:           header_q <= cfg_data_i;
        [CFG_TIME:CFG_QUAT]:  type_q[CFG_IDX_W'(cfg_idx_i - CFG_TIME)] <= cfg_data_i;
        CFG_CONV_EN:          conv_en_q <= cfg_data_i[NUM_KINDS-1:0];
        default:              header_q <= header_q;
      endcase
    end
  end

  // Byte cell chain: newest byte enters the last cell, oldest sits in cell zero
  for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_cell
    logic [7:0] nb;
    if (g == FRAME_BYTES - 1) begin : g_last
      assign nb = in_ch.rx_byte;
    end else begin : g_mid
      assign nb = win[g+1];
    end
    imu_fd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (acc),
      .data_i  (nb),
      .data_o  (win[g])
    );
  end

  // Track fill level and the running sum of the ten oldest bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      fill_q  <= '0;
      chk_v_q <= 1'b0;
    end else if (advance) begin
      chk_v_q <= acc && (fill_q >= FILL_W'(FRAME_BYTES - 1));
      if (acc) begin
        sum_q <= sum_q - win[0] + win[FRAME_BYTES-1];
        if (fill_q != FILL_W'(FRAME_BYTES)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Check header, checksum and type; lowest kind wins on equal type codes
  always_comb begin
    hdr_ok    = (win[0] == header_q);
    sum_ok    = (sum_q == win[FRAME_BYTES-1]);
    type_hit  = 1'b0;
    type_kind = KIND_TIME;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (win[1] == type_q[k]) begin
        type_hit  = 1'b1;
        type_kind = kind_e'(3'(k));
      end
    end
    for (int b = 0; b < PAY_BYTES; b++) begin
      pay[8*b +: 8] = win[b+2];
    end
  end

  // Match stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= chk_v_q && hdr_ok && sum_ok && type_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q <= type_kind;
      s1_pay_q  <= pay;
      s1_cv_q   <= (type_kind != KIND_TIME) && conv_en_q[type_kind];
    end
  end

  // Convert the four payload words
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_conv
    if (w == NUM_WORDS - 1) begin : g_quat
      assign ctl[w].en = s1_cv_q && (s1_kind_q == KIND_QUAT);
    end else begin : g_std
      assign ctl[w].en = s1_cv_q;
    end
    assign ctl[w].kind = s1_kind_q;
    imu_fd_conv u_conv (
      .ctl_i  (ctl[w]),
      .raw_i  (s1_pay_q[16*w +: 16]),
      .word_o (word[w])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= s1_kind_q;
      out_pay_q  <= s1_pay_q;
      out_cv_q   <= s1_cv_q;
      for (int w = 0; w < NUM_WORDS; w++) begin
        out_word_q[w] <= word[w];
      end
    end
  end

  assign out_ch.valid       = out_v_q;
  assign out_ch.frame_kind  = out_kind_q;
  assign out_ch.payload     = out_pay_q;
  assign out_ch.conv_first  = out_word_q[0];
  assign out_ch.conv_second = out_word_q[1];
  assign out_ch.conv_third  = out_word_q[2];
  assign out_ch.conv_fourth = out_word_q[3];
  assign out_ch.conv_valid  = out_cv_q;

  // Assertions
  `IMU_FD_ASSERT(a_fill_sat, fill_q <= FILL_W'(FRAME_BYTES), "fill count past frame size")
  `IMU_FD_ASSERT(a_chk_full, chk_v_q |-> fill_q == FILL_W'(FRAME_BYTES), "check on partial window")
  `IMU_FD_ASSERT(a_cv_kind, out_v_q && out_cv_q |-> out_kind_q != KIND_TIME, "time frame converted")
  `IMU_FD_ASSERT(a_fourth, out_v_q && out_word_q[3] != 0 |-> out_kind_q == KIND_QUAT, "stray word")

endmodule

// ===== tb/tb_imu_frame_decoder.sv =====
// Testbench of the IMU frame decoder: checks every decoded frame against a local predictor.
// Depends on imu_fd_pkg, imu_fd_ifs and the imu_frame_decoder RTL.
`timescale 1ns / 1ps

module tb_imu_frame_decoder;
  import imu_fd_pkg::*;

  // Q16.16 gains: full scale / 32768 * 65536
  localparam int ACCEL_GAIN   = 16 * 65536 / 32768;
  localparam int GYRO_GAIN    = 2000 * 65536 / 32768;
  localparam int ANGLE_GAIN   = 180 * 65536 / 32768;
  localparam int MAG_GAIN     = 65536;
  localparam int QUAT_GAIN    = 65536 / 32768;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 270;

  typedef struct {
    kind_e              kind;
    logic [63:0]        payload;
    logic signed [31:0] conv [NUM_WORDS];
    logic               conv_valid;
  } frame_t;

  typedef struct {
    logic [7:0] header;
    logic [7:0] code [NUM_KINDS];
    logic [7:0] conv_en;
  } settings_t;

  // Byte window predictor plus queue of frames still owed by the decoder
  class frame_scoreboard;
    logic [7:0]           header;
    logic [7:0]           code [NUM_KINDS];
    logic [NUM_KINDS-1:0] conv_en;
    logic [7:0]           window [FRAME_BYTES];
    int                   fill;
    frame_t               frames_due [$];
    int                   mismatches;
    int                   frames_checked;
    int                   kind_hits [NUM_KINDS];

    function new();
      header  = HEADER_RST;
      code    = '{TIME_RST, ACCEL_RST, GYRO_RST, ANGLE_RST, MAG_RST, QUAT_RST};
      conv_en = CONV_EN_RST;
      foreach (window[i]) window[i] = 8'h00;
      foreach (kind_hits[i]) kind_hits[i] = 0;
      fill           = 0;
      mismatches     = 0;
      frames_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_HEADER:  header  = data;
        CFG_TIME:    code[KIND_TIME]  = data;
        CFG_ACCEL:   code[KIND_ACCEL] = data;
        CFG_GYRO:    code[KIND_GYRO]  = data;
        CFG_ANGLE:   code[KIND_ANGLE] = data;
        CFG_MAG:     code[KIND_MAG]   = data;
        CFG_QUAT:    code[KIND_QUAT]  = data;
        CFG_CONV_EN: conv_en = data[NUM_KINDS-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] scale_word(kind_e k, logic [15:0] raw);
      int r;
      r = $signed(raw);
      case (k)
        KIND_ACCEL: return r * ACCEL_GAIN;
        KIND_GYRO:  return r * GYRO_GAIN;
        KIND_ANGLE: return r * ANGLE_GAIN;
        KIND_MAG:   return r * MAG_GAIN;
        KIND_QUAT:  return r * QUAT_GAIN;
        default:    return 32'sd0;
      endcase
    endfunction

    // Shift one byte in and queue a frame if the window now holds a known one
    function void note_byte(logic [7:0] b);
      logic [7:0] sum;
      int         k;
      frame_t     f;
      for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i+1];
      window[FRAME_BYTES-1] = b;
      if (fill < FRAME_BYTES) fill++;
      if (fill < FRAME_BYTES || window[0] != header) return;
      sum = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) sum += window[i];
      if (sum != window[FRAME_BYTES-1]) return;
      // lowest kind wins when codes collide
      k = NUM_KINDS;
      for (int i = NUM_KINDS - 1; i >= 0; i--) if (window[1] == code[i]) k = i;
      if (k == NUM_KINDS) return;
      f.kind = kind_e'(k);
      for (int i = 0; i < PAY_BYTES; i++) f.payload[8*i +: 8] = window[2+i];
      f.conv_valid = (f.kind != KIND_TIME) && conv_en[k];
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (f.conv_valid && (w < NUM_WORDS - 1 || f.kind == KIND_QUAT))
          f.conv[w] = scale_word(f.kind, f.payload[16*w +: 16]);
        else
          f.conv[w] = 32'sd0;
      end
      kind_hits[k]++;
      frames_due.push_back(f);
    endfunction

    function void check_frame(frame_t got);
      frame_t f;
      string  conv_name [NUM_WORDS];
      conv_name = '{"conv_first", "conv_second", "conv_third", "conv_fourth"};
      if (frames_due.size() == 0) begin
        $error("frame with no frame owed: kind %0d payload %h", got.kind, got.payload);
        mismatches++;
        return;
      end
      f = frames_due.pop_front();
      frames_checked++;
      if (got.kind !== f.kind) begin
        $error("frame_kind: expected %0d, actual %0d", f.kind, got.kind);
        mismatches++;
      end
      if (got.payload !== f.payload) begin
        $error("payload: expected %h, actual %h", f.payload, got.payload);
        mismatches++;
      end
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (got.conv[w] !== f.conv[w]) begin
          $error("%s: expected %0d, actual %0d", conv_name[w], f.conv[w], got.conv[w]);
          mismatches++;
        end
      end
      if (got.conv_valid !== f.conv_valid) begin
        $error("conv_valid: expected %0b, actual %0b", f.conv_valid, got.conv_valid);
        mismatches++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  imu_fd_in_if  in_ch ();
  imu_fd_out_if out_ch ();

  imu_frame_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  frame_scoreboard sb = new();

  settings_t cur;
  bit        no_idle     = 1'b0;
  int        sink_hold   = 0;
  int        bytes_sent  = 0;
  int        settings_run = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_HEADER;
    cfg_data       = 8'h00;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
  end

  // Result side: long hold when asked, otherwise random idling unless idling is off
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin : result_mon
    frame_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.kind       = kind_e'(out_ch.frame_kind);
      got.payload    = out_ch.payload;
      got.conv[0]    = out_ch.conv_first;
      got.conv[1]    = out_ch.conv_second;
      got.conv[2]    = out_ch.conv_third;
      got.conv[3]    = out_ch.conv_fourth;
      got.conv_valid = out_ch.conv_valid;
      sb.check_frame(got);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one byte, with random gaps in front unless idling is off, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] type_b, input logic [63:0] pay,
                            input bit good);
    logic [7:0] sum;
    sum = cur.header + type_b;
    for (int i = 0; i < PAY_BYTES; i++) sum += pay[8*i +: 8];
    if (!good) sum += 8'($urandom_range(1, 255));
    send_byte(cur.header);
    send_byte(type_b);
    for (int i = 0; i < PAY_BYTES; i++) send_byte(pay[8*i +: 8]);
    send_byte(sum);
  endtask

  // Drop valid, wait for every owed frame, then let the pipeline empty
  task automatic drain_frames();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Write all registers; upper enable bits are junk that must be masked
  task automatic write_settings(input settings_t s);
    write_reg(CFG_HEADER, s.header);
    write_reg(CFG_TIME, s.code[KIND_TIME]);
    write_reg(CFG_ACCEL, s.code[KIND_ACCEL]);
    write_reg(CFG_GYRO, s.code[KIND_GYRO]);
    write_reg(CFG_ANGLE, s.code[KIND_ANGLE]);
    write_reg(CFG_MAG, s.code[KIND_MAG]);
    write_reg(CFG_QUAT, s.code[KIND_QUAT]);
    write_reg(CFG_CONV_EN, {2'($urandom_range(3)), s.conv_en[NUM_KINDS-1:0]});
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur = s;
    settings_run++;
  endtask

  // Words biased toward the signed 16-bit extremes
  function automatic logic [63:0] rand_payload();
    logic [63:0] p;
    logic [15:0] edge_words [4];
    edge_words = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    for (int w = 0; w < NUM_WORDS; w++)
      p[16*w +: 16] = ($urandom_range(3) == 0) ? edge_words[$urandom_range(3)]
                                               : 16'($urandom);
    return p;
  endfunction

  // Mostly well formed frames, some with unknown type or bad checksum, noise between
  task automatic run_random(input int nbytes, input bit pause_midway);
    int   stop_at;
    logic [7:0] type_b;
    bit   paused;
    stop_at = bytes_sent + nbytes;
    paused  = 1'b0;
    while (bytes_sent < stop_at) begin
      if (pause_midway && !paused && bytes_sent > stop_at - nbytes / 2) begin
        drain_frames();
        paused = 1'b1;
      end
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(3) == 0) ? cur.header : 8'($urandom));
      end
      type_b = ($urandom_range(7) == 0) ? 8'($urandom) : cur.code[$urandom_range(5)];
      send_frame(type_b, rand_payload(), $urandom_range(7) != 0);
    end
  endtask

  initial begin : stimulus
    settings_t s;
    cur.header = HEADER_RST;
    cur.code   = '{TIME_RST, ACCEL_RST, GYRO_RST, ANGLE_RST, MAG_RST, QUAT_RST};
    cur.conv_en = CONV_EN_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quaternion frame with extreme words fills the window exactly,
    // then a time frame with an all-ones payload
    send_frame(QUAT_RST, 64'h0001_ffff_7fff_8000, 1'b1);
    send_frame(TIME_RST, 64'hffff_ffff_ffff_ffff, 1'b1);
    drain_frames();

    // Extreme codes, zero header equal to the time code, conversion off;
    // result side holds off at first so the decoder backs up
    s.header  = 8'h00;
    s.code    = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe};
    s.conv_en = 8'h00;
    write_settings(s);
    sink_hold = 150;
    run_random(PHASE_BYTES - 24, 1'b0);
    // run of zeros: every all-zero window is a valid overlapping time frame
    repeat (24) send_byte(8'h00);
    drain_frames();

    // Colliding type codes, all conversions on, no idling on either side
    s.header  = 8'hff;
    s.code    = '{8'h10, 8'h10, 8'h20, 8'h20, 8'h20, 8'h30};
    s.conv_en = 8'h3f;
    write_settings(s);
    no_idle = 1'b1;
    run_random(PHASE_BYTES, 1'b0);
    drain_frames();
    no_idle = 1'b0;

    // Fully random registers, sender pauses midway until all frames are out
    s.header = 8'($urandom);
    foreach (s.code[i]) s.code[i] = 8'($urandom);
    s.conv_en = 8'($urandom_range(63));
    write_settings(s);
    run_random(PHASE_BYTES, 1'b1);
    drain_frames();

    // Reset codes written back, alternating enable masks
    s.header  = HEADER_RST;
    s.code    = '{TIME_RST, ACCEL_RST, GYRO_RST, ANGLE_RST, MAG_RST, QUAT_RST};
    s.conv_en = 8'h2a;
    write_settings(s);
    run_random(PHASE_BYTES, 1'b0);
    drain_frames();

    s.header  = 8'haa;
    s.conv_en = 8'h15;
    write_settings(s);
    run_random(PHASE_BYTES, 1'b0);
    drain_frames();

    $display("Checked %0d frames from %0d bytes under %0d register settings.",
             sb.frames_checked, bytes_sent, settings_run + 1);
    $display("Frames per kind: time %0d accel %0d gyro %0d angle %0d mag %0d quat %0d",
             sb.kind_hits[KIND_TIME], sb.kind_hits[KIND_ACCEL], sb.kind_hits[KIND_GYRO],
             sb.kind_hits[KIND_ANGLE], sb.kind_hits[KIND_MAG], sb.kind_hits[KIND_QUAT]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
